[src/grid_cylinder_box_distance_field_defines.svh]
// Assertion helpers for the distance field block.
// Both forms sample on aclk and are off while aresetn is low.
`ifndef GRID_CYLINDER_BOX_DISTANCE_FIELD_DEFINES_SVH
`define GRID_CYLINDER_BOX_DISTANCE_FIELD_DEFINES_SVH
`ifndef SYNTHESIS
`define GCBDF_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gcbdf: check failed");
`define GCBDF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gcbdf: check failed");
`else
`define GCBDF_ASSERT_IMPL(name, ante, cons)
`define GCBDF_ASSERT_NEXT(name, ante, cons)
`endif
`endif

[src/gcbdf_pkg.sv]
package gcbdf_pkg;

    // grid and number format
    localparam int GRID_COLS  = 64;
    localparam int GRID_ROWS  = 64;
    localparam int MAX_LOOKUP = 2;
    localparam int FRAC_BITS  = 8;

    localparam int COL_W      = $clog2(GRID_COLS);
    localparam int ROW_W      = $clog2(GRID_ROWS);
    localparam int GRID_MAX   = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
    localparam int GRID_CNT_W = $clog2(GRID_MAX + 1);
    localparam int CLR_W      = $clog2(GRID_ROWS + 1);

    // field widths
    localparam int KIND_W   = 1;
    localparam int NCOL_W   = 6;
    localparam int NROW_W   = 6;
    localparam int PT_W     = 20;
    localparam int DIST_W   = 21;
    localparam int RAD_W    = 10;
    localparam int H_W      = 16;
    localparam int CELL_W   = 16;
    localparam int USE_W    = 7;

    // input tdata layout
    localparam int COL_LSB     = 0;
    localparam int ROW_LSB     = COL_LSB + NCOL_W;
    localparam int ON_BIT      = ROW_LSB + NROW_W;
    localparam int PX_LSB      = ON_BIT + 1;
    localparam int PY_LSB      = PX_LSB + PT_W;
    localparam int PZ_LSB      = PY_LSB + PT_W;
    localparam int IN_FIELDS_W = PZ_LSB + PT_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DIST_W + 7) / 8) * 8;

    // datapath widths
    localparam int IX_W     = PT_W - FRAC_BITS;
    localparam int NX_W     = IX_W + 1;
    localparam int LOOK_W   = $clog2(MAX_LOOKUP + 1);
    localparam int DX_W     = LOOK_W + 1;
    localparam int E_W      = FRAC_BITS + LOOK_W + 2;
    localparam int MAG_W    = E_W - 1;
    localparam int SQ_W     = 2 * E_W;
    localparam int ROOT_W   = E_W;
    localparam int STEP_W   = $clog2(ROOT_W + 1);
    localparam int BEST_W   = PT_W + 2;
    localparam int RAD_UP_W = RAD_W + 1;
    localparam int CEIL_W   = RAD_UP_W - FRAC_BITS;

    localparam int ONE_FIX  = 1 << FRAC_BITS;
    localparam int HALF_FIX = 1 << (FRAC_BITS - 1);

    localparam logic signed [BEST_W-1:0] DIST_MAX_B = BEST_W'((1 << (DIST_W - 1)) - 1);
    localparam logic signed [BEST_W-1:0] DIST_MIN_B = -BEST_W'(1 << (DIST_W - 1));

    // APB
    localparam int NUM_REGS  = 5;
    localparam int PADDR_W   = $clog2(NUM_REGS * 4);
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam int PDATA_W   = 32;

    localparam logic [RAD_W-1:0]  RAD_RST  = RAD_W'(256);
    localparam logic [H_W-1:0]    H_RST    = H_W'(256);
    localparam logic [CELL_W-1:0] CELL_RST = CELL_W'(64);
    localparam logic [USE_W-1:0]  USE_RST  = '0;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_NODE_RADIUS = 3'd0,
        REG_SLAB_HEIGHT = 3'd1,
        REG_CELL_SIZE   = 3'd2,
        REG_COLS_IN_USE = 3'd3,
        REG_ROWS_IN_USE = 3'd4
    } reg_idx_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD = 1'b0,
        KIND_EVAL = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_TEST,
        ST_SQR,
        ST_ROOT,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic [RAD_W-1:0]  node_radius;
        logic [H_W-1:0]    slab_height;
        logic [CELL_W-1:0] cell_size;
        logic [USE_W-1:0]  columns_in_use;
        logic [USE_W-1:0]  rows_in_use;
    } cfg_t;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             value;
    } ram_wr_t;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] distance;
    } result_t;

endpackage

[src/gcbdf_node_ram.sv]
module gcbdf_node_ram import gcbdf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ram_wr_t              wr,
    input  logic [ROW_W-1:0]     rd_addr_a,
    input  logic [ROW_W-1:0]     rd_addr_b,
    output logic [GRID_COLS-1:0] rd_data_a,
    output logic [GRID_COLS-1:0] rd_data_b,
    output logic                 clear_busy
);

    // one row of nodes per word
    logic [GRID_COLS-1:0] mem [GRID_ROWS];
    logic [CLR_W-1:0]     clr_cnt_reg;

    assign clear_busy = (32'(clr_cnt_reg) < GRID_ROWS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (clear_busy) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (clear_busy) begin
            mem[clr_cnt_reg[ROW_W-1:0]] <= '0;
        end else if (wr.en) begin
            mem[wr.row][wr.col] <= wr.value;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

[src/gcbdf_isqrt.sv]
`include "grid_cylinder_box_distance_field_defines.svh"

module gcbdf_isqrt import gcbdf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    // restoring square root, one result bit per cycle
    logic [SQ_W-1:0]   rem_reg;
    logic [SQ_W-1:0]   res_reg;
    logic [SQ_W-1:0]   bit_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [SQ_W-1:0]   trial;
    logic              take;

    assign trial    = res_reg + bit_reg;
    assign take     = (rem_reg >= trial);
    assign rsp.done = done_reg;
    assign rsp.root = res_reg[ROOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= STEP_W'(ROOT_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.radicand;
            res_reg <= '0;
            bit_reg <= SQ_W'(1) << (SQ_W - 2);
        end else if (busy_reg) begin
            if (take) begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    `GCBDF_ASSERT_NEXT(a_done_single, done_reg, !done_reg)
    `GCBDF_ASSERT_IMPL(a_busy_count, busy_reg, cnt_reg != '0)

endmodule

[src/gcbdf_seq.sv]
`include "grid_cylinder_box_distance_field_defines.svh"

module gcbdf_seq import gcbdf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  s_tuser,
    input  logic                  out_free,
    output result_t               result,
    output ram_wr_t               ram_wr,
    output logic [ROW_W-1:0]      ram_addr_a,
    output logic [ROW_W-1:0]      ram_addr_b,
    input  logic [GRID_COLS-1:0]  ram_data_a,
    input  logic [GRID_COLS-1:0]  ram_data_b,
    input  logic                  ram_clearing,
    output sqrt_req_t             sqrt_req,
    input  sqrt_rsp_t             sqrt_rsp
);

    seq_state_t                state_reg, state_next;
    logic [FRAC_BITS-1:0]      fx_reg, fx_next, fz_reg, fz_next;
    logic signed [IX_W-1:0]    ix_reg, ix_next, iz_reg, iz_next;
    logic signed [BEST_W-1:0]  qy_reg, qy_next, best_reg, best_next;
    logic [LOOK_W-1:0]         look_reg, look_next;
    logic signed [DX_W-1:0]    dx_reg, dx_next, dz_reg, dz_next;
    logic [GRID_CNT_W-1:0]     cols_reg, cols_next, rows_reg, rows_next;
    logic [2*MAG_W-1:0]        sqx_reg, sqx_next, sqz_reg, sqz_next;

    // input fields
    logic [NCOL_W-1:0]         in_col;
    logic [NROW_W-1:0]         in_row;
    logic                      in_on;
    logic signed [PT_W-1:0]    in_px, in_py, in_pz;
    logic                      load_in_grid;

    // capture-time values
    logic signed [BEST_W-1:0]  py_b, h_b;
    logic [RAD_UP_W-1:0]       rad_up;
    logic [CEIL_W-1:0]         look_ceil;
    logic [LOOK_W-1:0]         look_new;
    logic [GRID_CNT_W-1:0]     cols_sat, rows_sat;

    // window position
    logic signed [DX_W-1:0]    look_s;
    logic signed [NX_W-1:0]    nx, nz, cols_s, rows_s;
    logic [COL_W-1:0]          col0, col1;
    logic                      in_x, in_z, in_x1, in_z1;
    logic                      node_on, cell_full;
    logic signed [E_W-1:0]     ex, ez, qx, qz;
    logic [MAG_W-1:0]          mag_x, mag_z;
    logic signed [BEST_W-1:0]  box_t, radial, cyl_t;
    logic [DIST_W-1:0]         dist_sat;

    // step to next position
    logic signed [DX_W-1:0]    adv_dx, adv_dz;
    seq_state_t                adv_state;

    assign in_col = s_tdata[COL_LSB +: NCOL_W];
    assign in_row = s_tdata[ROW_LSB +: NROW_W];
    assign in_on  = s_tdata[ON_BIT];
    assign in_px  = s_tdata[PX_LSB +: PT_W];
    assign in_py  = s_tdata[PY_LSB +: PT_W];
    assign in_pz  = s_tdata[PZ_LSB +: PT_W];
    assign load_in_grid = (32'(in_col) < GRID_COLS) && (32'(in_row) < GRID_ROWS);

    // cap term: (|2y - H| - H) / 2 is y - H above mid height, -y below
    assign py_b = BEST_W'(in_py);
    assign h_b  = $signed(BEST_W'(cfg.slab_height));

    assign rad_up    = RAD_UP_W'(cfg.node_radius) + RAD_UP_W'(ONE_FIX - 1);
    assign look_ceil = rad_up[RAD_UP_W-1:FRAC_BITS];

    always_comb begin
        if (look_ceil == '0) begin
            look_new = LOOK_W'(1);
        end else if (32'(look_ceil) > MAX_LOOKUP) begin
            look_new = LOOK_W'(MAX_LOOKUP);
        end else begin
            look_new = LOOK_W'(look_ceil);
        end
        cols_sat = (32'(cfg.columns_in_use) > GRID_COLS) ? GRID_CNT_W'(GRID_COLS)
                                                        : GRID_CNT_W'(cfg.columns_in_use);
        rows_sat = (32'(cfg.rows_in_use) > GRID_ROWS) ? GRID_CNT_W'(GRID_ROWS)
                                                     : GRID_CNT_W'(cfg.rows_in_use);
        if (cols_sat <= GRID_CNT_W'(1) || rows_sat <= GRID_CNT_W'(1)) begin
            cols_sat = '0;
            rows_sat = '0;
        end
    end

    assign look_s = $signed({1'b0, look_reg});
    assign nx     = NX_W'(ix_reg) + NX_W'(dx_reg);
    assign nz     = NX_W'(iz_reg) + NX_W'(dz_reg);
    assign cols_s = $signed(NX_W'(cols_reg));
    assign rows_s = $signed(NX_W'(rows_reg));

    assign ram_addr_a = nz[ROW_W-1:0];
    assign ram_addr_b = nz[ROW_W-1:0] + 1'b1;
    assign col0       = nx[COL_W-1:0];
    assign col1       = col0 + 1'b1;

    assign in_x  = (nx >= 0) && (nx < cols_s);
    assign in_z  = (nz >= 0) && (nz < rows_s);
    assign in_x1 = (nx + NX_W'(1)) < cols_s;
    assign in_z1 = (nz + NX_W'(1)) < rows_s;

    assign node_on   = in_x && in_z && ram_data_a[col0];
    assign cell_full = in_x && in_z && in_x1 && in_z1 &&
                       ram_data_a[col0] && ram_data_a[col1] &&
                       ram_data_b[col0] && ram_data_b[col1];

    // offset from the node: fraction minus window step
    assign ex = $signed(E_W'(fx_reg)) - (E_W'(dx_reg) <<< FRAC_BITS);
    assign ez = $signed(E_W'(fz_reg)) - (E_W'(dz_reg) <<< FRAC_BITS);

    assign mag_x = ex[E_W-1] ? MAG_W'(-ex) : MAG_W'(ex);
    assign mag_z = ez[E_W-1] ? MAG_W'(-ez) : MAG_W'(ez);

    // box slab term over one cell
    assign qx = (ex >= $signed(E_W'(HALF_FIX))) ? ex - $signed(E_W'(ONE_FIX)) : -ex;
    assign qz = (ez >= $signed(E_W'(HALF_FIX))) ? ez - $signed(E_W'(ONE_FIX)) : -ez;

    always_comb begin
        box_t = qy_reg;
        if (BEST_W'(qx) > box_t) begin
            box_t = BEST_W'(qx);
        end
        if (BEST_W'(qz) > box_t) begin
            box_t = BEST_W'(qz);
        end
    end

    assign radial = $signed(BEST_W'(sqrt_rsp.root)) - $signed(BEST_W'(cfg.node_radius));
    assign cyl_t  = (radial > qy_reg) ? radial : qy_reg;

    always_comb begin
        if (best_reg > DIST_MAX_B) begin
            dist_sat = DIST_MAX_B[DIST_W-1:0];
        end else if (best_reg < DIST_MIN_B) begin
            dist_sat = DIST_MIN_B[DIST_W-1:0];
        end else begin
            dist_sat = best_reg[DIST_W-1:0];
        end
    end

    always_comb begin
        adv_dx    = dx_reg + DX_W'(1);
        adv_dz    = dz_reg;
        adv_state = ST_ADDR;
        if (dx_reg == look_s) begin
            adv_dx = -look_s;
            if (dz_reg == look_s) begin
                adv_state = ST_DONE;
            end else begin
                adv_dz = dz_reg + DX_W'(1);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        fx_next    = fx_reg;
        fz_next    = fz_reg;
        ix_next    = ix_reg;
        iz_next    = iz_reg;
        qy_next    = qy_reg;
        best_next  = best_reg;
        look_next  = look_reg;
        dx_next    = dx_reg;
        dz_next    = dz_reg;
        cols_next  = cols_reg;
        rows_next  = rows_reg;
        sqx_next   = sqx_reg;
        sqz_next   = sqz_reg;

        s_tready          = 1'b0;
        ram_wr            = '0;
        sqrt_req.start    = 1'b0;
        sqrt_req.radicand = SQ_W'(sqx_reg) + SQ_W'(sqz_reg);
        result.valid      = 1'b0;
        result.distance   = dist_sat;

        case (state_reg)
            ST_IDLE: begin
                s_tready = !ram_clearing;
                if (s_tvalid && !ram_clearing) begin
                    if (kind_t'(s_tuser) == KIND_LOAD) begin
                        ram_wr.en    = load_in_grid;
                        ram_wr.row   = ROW_W'(in_row);
                        ram_wr.col   = COL_W'(in_col);
                        ram_wr.value = in_on;
                    end else begin
                        fx_next   = in_px[FRAC_BITS-1:0];
                        fz_next   = in_pz[FRAC_BITS-1:0];
                        ix_next   = in_px[PT_W-1:FRAC_BITS];
                        iz_next   = in_pz[PT_W-1:FRAC_BITS];
                        qy_next   = ((py_b <<< 1) >= h_b) ? py_b - h_b : -py_b;
                        best_next = $signed(BEST_W'({cfg.cell_size, 1'b0}));
                        look_next = look_new;
                        dx_next   = -$signed({1'b0, look_new});
                        dz_next   = -$signed({1'b0, look_new});
                        cols_next = cols_sat;
                        rows_next = rows_sat;
                        state_next = ST_ADDR;
                    end
                end
            end
            ST_ADDR: begin
                state_next = ST_TEST;
            end
            ST_TEST: begin
                sqx_next = mag_x * mag_x;
                sqz_next = mag_z * mag_z;
                if (cell_full && box_t < best_reg) begin
                    best_next = box_t;
                end
                if (node_on) begin
                    state_next = ST_SQR;
                end else begin
                    dx_next    = adv_dx;
                    dz_next    = adv_dz;
                    state_next = adv_state;
                end
            end
            ST_SQR: begin
                sqrt_req.start = 1'b1;
                state_next     = ST_ROOT;
            end
            ST_ROOT: begin
                if (sqrt_rsp.done) begin
                    if (cyl_t < best_next) begin
                        best_next = cyl_t;
                    end
                    dx_next    = adv_dx;
                    dz_next    = adv_dz;
                    state_next = adv_state;
                end
            end
            ST_DONE: begin
                result.valid = 1'b1;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        fx_reg   <= fx_next;
        fz_reg   <= fz_next;
        ix_reg   <= ix_next;
        iz_reg   <= iz_next;
        qy_reg   <= qy_next;
        best_reg <= best_next;
        look_reg <= look_next;
        dx_reg   <= dx_next;
        dz_reg   <= dz_next;
        cols_reg <= cols_next;
        rows_reg <= rows_next;
        sqx_reg  <= sqx_next;
        sqz_reg  <= sqz_next;
    end

    `GCBDF_ASSERT_IMPL(a_root_in_wait, sqrt_rsp.done, state_reg == ST_ROOT)
    `GCBDF_ASSERT_IMPL(a_step_in_window, state_reg == ST_TEST, dx_reg <= look_s && dx_reg >= -look_s)
    `GCBDF_ASSERT_IMPL(a_result_after_scan, result.valid, dz_reg == look_s && dx_reg == -look_s)

endmodule

[src/grid_cylinder_box_distance_field.sv]
// Signed distance field over a 64 x 64 node map: capped cylinders around raised
// nodes and unit boxes over cells whose four corners are raised, clipped to the
// slab 0..slab_height in y. A request with s_tuser = 0 writes one node bit and
// gives no result. A request with s_tuser = 1 evaluates a point and gives one
// 21-bit signed Q.8 distance on m_tdata. Evaluation scans the (2L+1)^2 window
// around the point's cell, L being 1 or 2 from node_radius: each window position
// is a node map row read, then a test, and each raised node in the window also
// goes through the single bit-serial square root unit (12 root bits); then the
// result is handed off and the next request taken. s_tready is low while a
// point is in work. The result sits in an output register, so the next request
// is taken while it waits on m_tready. After reset the node map is cleared one
// row per cycle: s_tready stays low until the clear is done (configuration
// writes are taken throughout). Registers are on the APB port at byte addresses
// 0 node_radius, 4 slab_height, 8 cell_size, 12 columns_in_use, 16 rows_in_use;
// write them only while the block is idle.
module grid_cylinder_box_distance_field import gcbdf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // APB configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready,
    // request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // node_col[5:0], node_row[11:6], node_on[12], point_x[32:13],
    // point_y[52:33], point_z[72:53], zero[79:73]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // kind: 0 load node, 1 evaluate point
    input  logic                   s_tuser,
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // distance[20:0], zero[23:21]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [RAD_W-1:0]  rad_reg;
    logic [H_W-1:0]    h_reg;
    logic [CELL_W-1:0] cell_reg;
    logic [USE_W-1:0]  cols_reg;
    logic [USE_W-1:0]  rows_reg;
    cfg_t              cfg;
    reg_idx_t          reg_idx;
    logic              cfg_wr;

    logic              m_tvalid_reg;
    logic [DIST_W-1:0] m_dist_reg;
    logic              out_free;
    result_t           result;

    ram_wr_t              ram_wr;
    logic [ROW_W-1:0]     ram_addr_a, ram_addr_b;
    logic [GRID_COLS-1:0] ram_data_a, ram_data_b;
    logic                 ram_clearing;

    sqrt_req_t sqrt_req;
    sqrt_rsp_t sqrt_rsp;

    // ---------------------------------------------------------------- APB
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rad_reg  <= RAD_RST;
            h_reg    <= H_RST;
            cell_reg <= CELL_RST;
            cols_reg <= USE_RST;
            rows_reg <= USE_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_NODE_RADIUS: rad_reg  <= pwdata[RAD_W-1:0];
                REG_SLAB_HEIGHT: h_reg    <= pwdata[H_W-1:0];
                REG_CELL_SIZE:   cell_reg <= pwdata[CELL_W-1:0];
                REG_COLS_IN_USE: cols_reg <= pwdata[USE_W-1:0];
                REG_ROWS_IN_USE: rows_reg <= pwdata[USE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_NODE_RADIUS: prdata = PDATA_W'(rad_reg);
            REG_SLAB_HEIGHT: prdata = PDATA_W'(h_reg);
            REG_CELL_SIZE:   prdata = PDATA_W'(cell_reg);
            REG_COLS_IN_USE: prdata = PDATA_W'(cols_reg);
            REG_ROWS_IN_USE: prdata = PDATA_W'(rows_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.node_radius    = rad_reg;
    assign cfg.slab_height    = h_reg;
    assign cfg.cell_size      = cell_reg;
    assign cfg.columns_in_use = cols_reg;
    assign cfg.rows_in_use    = rows_reg;

    // ---------------------------------------------------------- datapath
    gcbdf_node_ram u_ram (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr         (ram_wr),
        .rd_addr_a  (ram_addr_a),
        .rd_addr_b  (ram_addr_b),
        .rd_data_a  (ram_data_a),
        .rd_data_b  (ram_data_b),
        .clear_busy (ram_clearing)
    );

    gcbdf_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .rsp     (sqrt_rsp)
    );

    gcbdf_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .out_free     (out_free),
        .result       (result),
        .ram_wr       (ram_wr),
        .ram_addr_a   (ram_addr_a),
        .ram_addr_b   (ram_addr_b),
        .ram_data_a   (ram_data_a),
        .ram_data_b   (ram_data_b),
        .ram_clearing (ram_clearing),
        .sqrt_req     (sqrt_req),
        .sqrt_rsp     (sqrt_rsp)
    );

    // ------------------------------------------------------ output register
    // free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (result.valid && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid && out_free) begin
            m_dist_reg <= result.distance;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - DIST_W){1'b0}}, m_dist_reg};

endmodule

[test/grid_cylinder_box_distance_field_tb.sv]
module grid_cylinder_box_distance_field_tb import gcbdf_pkg::*; ();

    localparam int CLK_PERIOD   = 8;
    // this leaves a wide margin over the slowest legal run
    localparam int LIMIT_CYCLES = 3_000_000;
    // loads are written as they are taken, so a short settle covers the idle requirement
    localparam int SETTLE_CYCLES = 16;
    // the longest evaluation is the one with a full window
    localparam int TAIL_CYCLES   = 500;

    localparam longint DIST_HI = (longint'(1) << (DIST_W - 1)) - 1;
    localparam longint DIST_LO = -(longint'(1) << (DIST_W - 1));

    logic                   aclk;
    logic                   aresetn;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   s_tvalid;
    logic                   s_tready;
    // node_col, node_row, node_on, point_x, point_y, point_z, zero pad
    logic [IN_TDATA_W-1:0]  s_tdata;
    // kind
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // distance, zero pad
    logic [OUT_TDATA_W-1:0] m_tdata;

    grid_cylinder_box_distance_field i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow of the block: node map and register file
    logic              node_bits [GRID_ROWS][GRID_COLS];
    logic [RAD_W-1:0]  cfg_radius = RAD_RST;
    logic [H_W-1:0]    cfg_height = H_RST;
    logic [CELL_W-1:0] cfg_cell   = CELL_RST;
    logic [USE_W-1:0]  cfg_cols   = USE_RST;
    logic [USE_W-1:0]  cfg_rows   = USE_RST;

    // distances still owed by the block, oldest first
    logic [DIST_W-1:0] expected_dist_q [$];

    int error_count    = 0;
    int eval_count     = 0;
    int load_count     = 0;
    int setting_count  = 0;

    // idle controls shared with the source and sink sides
    bit src_idle_en      = 1'b1;
    bit sink_idle_en     = 1'b1;
    int sink_hold_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("grid_cylinder_box_distance_field test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Distance prediction
    // ------------------------------------------------------------------

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // floor square root, one result bit at a time
    function automatic longint root_floor(longint v);
        longint root;
        longint trial;
        root = 0;
        for (int b = 30; b >= 0; b--) begin
            trial = root + (longint'(1) << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // nodes outside the columns/rows in use count as lowered
    function automatic logic node_raised(longint c, longint r, longint cols, longint rows);
        if (c < 0 || c >= cols || r < 0 || r >= rows)
            return 1'b0;
        return node_bits[r][c];
    endfunction

    function automatic logic cell_full(longint c, longint r, longint cols, longint rows);
        if (c < 0 || c >= cols - 1 || r < 0 || r >= rows - 1)
            return 1'b0;
        return node_raised(c, r, cols, rows) && node_raised(c + 1, r, cols, rows) &&
               node_raised(c, r + 1, cols, rows) && node_raised(c + 1, r + 1, cols, rows);
    endfunction

    function automatic logic [DIST_W-1:0] predict_distance(
        logic signed [PT_W-1:0] px_in, logic signed [PT_W-1:0] py_in,
        logic signed [PT_W-1:0] pz_in);
        longint px, py, pz, cols, rows, rad, h, look, ix, iz;
        longint qy, qx, qz, best, nx, nz, ddx, ddz, term, dx, dz;
        px = px_in;
        py = py_in;
        pz = pz_in;
        cols = (cfg_cols > GRID_COLS) ? GRID_COLS : cfg_cols;
        rows = (cfg_rows > GRID_ROWS) ? GRID_ROWS : cfg_rows;
        // a single column or row means an empty map
        if (cols <= 1 || rows <= 1) begin
            cols = 0;
            rows = 0;
        end
        rad  = cfg_radius;
        h    = cfg_height;
        look = (rad + ONE_FIX - 1) >>> FRAC_BITS;
        if (look < 1)
            look = 1;
        if (look > MAX_LOOKUP)
            look = MAX_LOOKUP;
        ix   = px >>> FRAC_BITS;
        iz   = pz >>> FRAC_BITS;
        qy   = (mag(2 * py - h) - h) / 2;
        best = 2 * longint'(cfg_cell);
        for (dz = -look; dz <= look; dz++) begin
            for (dx = -look; dx <= look; dx++) begin
                nx = ix + dx;
                nz = iz + dz;
                if (node_raised(nx, nz, cols, rows)) begin
                    ddx  = mag(px - nx * ONE_FIX);
                    ddz  = mag(pz - nz * ONE_FIX);
                    term = root_floor(ddx * ddx + ddz * ddz) - rad;
                    if (qy > term)
                        term = qy;
                    if (term < best)
                        best = term;
                end
                if (cell_full(nx, nz, cols, rows)) begin
                    qx   = (mag(2 * px - (2 * nx + 1) * ONE_FIX) - ONE_FIX) / 2;
                    qz   = (mag(2 * pz - (2 * nz + 1) * ONE_FIX) - ONE_FIX) / 2;
                    term = (qx > qz) ? qx : qz;
                    if (qy > term)
                        term = qy;
                    if (term < best)
                        best = term;
                end
            end
        end
        if (best > DIST_HI)
            best = DIST_HI;
        if (best < DIST_LO)
            best = DIST_LO;
        return best[DIST_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    function automatic logic [IN_TDATA_W-1:0] request_word(
        logic [NCOL_W-1:0] col, logic [NROW_W-1:0] row, logic on,
        logic signed [PT_W-1:0] px, logic signed [PT_W-1:0] py,
        logic signed [PT_W-1:0] pz);
        return IN_TDATA_W'({pz, py, px, on, row, col});
    endfunction

    // Offers one request, optionally after a random idle burst, and updates
    // the shadow map or queues the expected distance once it is taken.
    // Returns at the accepting edge; valid stays high for a following request.
    task automatic send_request(kind_t kind, logic [IN_TDATA_W-1:0] word);
        int gap;
        gap = (src_idle_en && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 16)) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= word;
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (kind == KIND_LOAD) begin
            node_bits[word[ROW_LSB +: NROW_W]][word[COL_LSB +: NCOL_W]] = word[ON_BIT];
            load_count++;
        end else begin
            expected_dist_q.push_back(predict_distance(word[PX_LSB +: PT_W],
                                                       word[PY_LSB +: PT_W],
                                                       word[PZ_LSB +: PT_W]));
            eval_count++;
        end
    endtask

    task automatic send_load(int col, int row, logic on);
        send_request(KIND_LOAD, request_word(NCOL_W'(col), NROW_W'(row), on, '0, '0, '0));
    endtask

    task automatic send_eval(int px, int py, int pz);
        send_request(KIND_EVAL, request_word('0, '0, 1'b0, PT_W'(px), PT_W'(py), PT_W'(pz)));
    endtask

    // mostly cells around the populated corner of the map, some near the far
    // edge, some anywhere in the 20-bit range; integer positions are common
    function automatic logic signed [PT_W-1:0] pick_coord();
        int cell_i;
        int frac;
        frac = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, ONE_FIX - 1));
        case ($urandom_range(0, 9))
            0:       return PT_W'($urandom);
            1:       cell_i = int'($urandom_range(56, 68));
            default: cell_i = int'($urandom_range(0, 17)) - 3;
        endcase
        return PT_W'(cell_i * ONE_FIX + frac);
    endfunction

    // heights around the slab, with a margin below and above
    function automatic logic signed [PT_W-1:0] pick_height();
        int span;
        if ($urandom_range(0, 7) == 0)
            return PT_W'($urandom);
        span = 2 * int'(cfg_height) + 1024;
        return PT_W'(int'($urandom_range(0, span)) - 512);
    endfunction

    task automatic random_request(int eval_pct);
        logic [NCOL_W-1:0] col;
        logic [NROW_W-1:0] row;
        logic              on;
        kind_t             kind;
        if ($urandom_range(0, 3) == 0) begin
            col = NCOL_W'($urandom_range(0, GRID_COLS - 1));
            row = NROW_W'($urandom_range(0, GRID_ROWS - 1));
        end else begin
            // dense corner so that full cells show up
            col = NCOL_W'($urandom_range(0, 11));
            row = NROW_W'($urandom_range(0, 11));
        end
        on   = ($urandom_range(0, 2) != 0);
        kind = ($urandom_range(0, 99) < eval_pct) ? KIND_EVAL : KIND_LOAD;
        send_request(kind, request_word(col, row, on, pick_coord(), pick_height(),
                                        pick_coord()));
    endtask

    // sender stops and waits for every owed distance, then lets loads settle
    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_dist_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------

    task automatic cfg_check(reg_idx_t idx);
        logic [PDATA_W-1:0] want;
        case (idx)
            REG_NODE_RADIUS: want = PDATA_W'(cfg_radius);
            REG_SLAB_HEIGHT: want = PDATA_W'(cfg_height);
            REG_CELL_SIZE:   want = PDATA_W'(cfg_cell);
            REG_COLS_IN_USE: want = PDATA_W'(cfg_cols);
            REG_ROWS_IN_USE: want = PDATA_W'(cfg_rows);
            default:         want = '0;
        endcase
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'({idx, 2'b00});
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (prdata !== want) begin
            error_count++;
            $display("%0t register %s read: expected %0d actual %0d",
                     $time, idx.name(), want, prdata);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write, mirror into the shadow at the write edge, then read back
    task automatic cfg_write(reg_idx_t idx, int unsigned value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        case (idx)
            REG_NODE_RADIUS: cfg_radius = value[RAD_W-1:0];
            REG_SLAB_HEIGHT: cfg_height = value[H_W-1:0];
            REG_CELL_SIZE:   cfg_cell   = value[CELL_W-1:0];
            REG_COLS_IN_USE: cfg_cols   = value[USE_W-1:0];
            REG_ROWS_IN_USE: cfg_rows   = value[USE_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_check(idx);
    endtask

    // one register setting followed by a block of random requests
    task automatic run_setting(int unsigned rad, int unsigned h, int unsigned cell_sz,
                               int unsigned cols, int unsigned rows, int n_items);
        wait_results_drained();
        cfg_write(REG_NODE_RADIUS, rad);
        cfg_write(REG_SLAB_HEIGHT, h);
        cfg_write(REG_CELL_SIZE, cell_sz);
        cfg_write(REG_COLS_IN_USE, cols);
        cfg_write(REG_ROWS_IN_USE, rows);
        setting_count++;
        src_idle_en  = ($urandom_range(0, 3) != 0);
        sink_idle_en = ($urandom_range(0, 3) != 0);
        repeat (n_items) random_request(55);
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // sink ready: random stall bursts, or a long hold-off
    // requested through sink_hold_cycles
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (sink_hold_cycles - 1) @(negedge aclk);
                sink_hold_cycles = 0;
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                if (sink_idle_en)
                    repeat ($urandom_range(0, 15)) @(negedge aclk);
            end
        end
    end

    // every taken result is matched against the oldest owed distance
    initial begin
        logic [DIST_W-1:0] want;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
                if (expected_dist_q.size() == 0) begin
                    error_count++;
                    $display("%0t unexpected result: expected none actual %0d",
                             $time, $signed(m_tdata[DIST_W-1:0]));
                end else begin
                    want = expected_dist_q.pop_front();
                    if (m_tdata !== OUT_TDATA_W'(want)) begin
                        error_count++;
                        $display("%0t distance mismatch: expected %0d actual %0d (tdata %h)",
                                 $time, $signed(want), $signed(m_tdata[DIST_W-1:0]),
                                 m_tdata);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset values, and the empty-map rule with columns_in_use at zero
    task automatic test_reset_defaults();
        cfg_check(REG_NODE_RADIUS);
        cfg_check(REG_SLAB_HEIGHT);
        cfg_check(REG_CELL_SIZE);
        cfg_check(REG_COLS_IN_USE);
        cfg_check(REG_ROWS_IN_USE);
        send_load(0, 0, 1'b1);
        send_eval(0, 0, 0);
        wait_results_drained();
    endtask

    // hand-picked shapes: one full cell, far corner nodes, cleared node,
    // negative floor, slab top, coordinate extremes
    task automatic test_directed_shapes();
        cfg_write(REG_COLS_IN_USE, GRID_COLS);
        cfg_write(REG_ROWS_IN_USE, GRID_ROWS);
        cfg_write(REG_CELL_SIZE, 2048);
        setting_count++;
        send_load(1, 0, 1'b1);
        send_load(0, 1, 1'b1);
        send_load(1, 1, 1'b1);
        send_load(GRID_COLS - 1, GRID_ROWS - 1, 1'b1);
        send_load(GRID_COLS - 1, 0, 1'b1);
        send_load(5, 5, 1'b1);
        send_load(5, 5, 1'b0);
        send_eval(0, 0, 0);
        send_eval(128, 128, 128);
        send_eval(-256, 0, -256);
        send_eval((GRID_COLS - 1) * ONE_FIX, 256, (GRID_ROWS - 1) * ONE_FIX);
        send_eval((GRID_COLS - 1) * ONE_FIX + 255, 300, 255);
        send_eval(-524288, -524288, -524288);
        send_eval(524287, 524287, 524287);
        send_eval(5 * ONE_FIX, 128, 5 * ONE_FIX);
        // breaking the cell leaves only the cylinders
        send_load(1, 1, 1'b0);
        send_eval(128, 128, 128);
        wait_results_drained();
    endtask

    // register sweep including extremes: zero radius and height, largest
    // values, radius beyond the lookup window, zero cell size, counts beyond
    // the grid, smallest usable grid, a single column and zero rows
    task automatic test_register_sweep();
        run_setting(256, 256, 512, 64, 64, 125);
        run_setting(0, 0, 1, 64, 64, 125);
        run_setting(512, 65535, 65535, 64, 64, 125);
        run_setting(1023, 1024, 0, 100, 127, 125);
        run_setting(1, 300, 300, 2, 2, 125);
        run_setting(128, 512, 1000, 1, 64, 125);
        run_setting(384, 700, 2000, 12, 40, 125);
        run_setting(300, 256, 800, 64, 0, 125);
        run_setting(200, 100, 4096, 33, 64, 125);
    endtask

    // sink holds off long enough for the output register to fill and the
    // block to push back on requests that keep being offered
    task automatic test_sink_holdoff();
        run_setting(256, 512, 1024, 64, 64, 0);
        src_idle_en      = 1'b0;
        sink_hold_cycles = 400;
        repeat (40) random_request(80);
        wait_results_drained();
    endtask

    // sender stops mid-stream until every owed result is back
    task automatic test_sender_pause();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        repeat (15) random_request(60);
        wait_results_drained();
        repeat (15) random_request(60);
        wait_results_drained();
    endtask

    // closing stretch with both sides always ready
    task automatic test_no_idle_tail();
        wait_results_drained();
        cfg_write(REG_NODE_RADIUS, 384);
        cfg_write(REG_SLAB_HEIGHT, 512);
        cfg_write(REG_CELL_SIZE, 1024);
        setting_count++;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (150) random_request(55);
        wait_results_drained();
    endtask

    initial begin
        foreach (node_bits[r, c])
            node_bits[r][c] = 1'b0;
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_directed_shapes();
        test_register_sweep();
        test_sink_holdoff();
        test_sender_pause();
        test_no_idle_tail();

        // catch any stray result after the last owed one
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run covered %0d point evaluations and %0d node loads over %0d register settings",
                 eval_count, load_count, setting_count);
        $display("with random stalls on both sides, a long sink hold-off and %0d errors",
                 error_count);
        if (error_count == 0) begin
            $display("grid_cylinder_box_distance_field test passed");
        end else begin
            $display("grid_cylinder_box_distance_field test failed");
        end
        $finish;
    end

endmodule
